### hw/rtl/nps_pkg.sv
// ----------------------------------------------------------------------------
// Nearest point search package
// Shared widths, request codes and the front-to-back control struct.
// ----------------------------------------------------------------------------
package nps_pkg;

    localparam int SLOT_W  = 10;
    localparam int CNT_W   = 11;
    localparam int IDX_W   = 10;
    localparam int DIST_W  = 50;

    // Command queue between the front and the back.
    localparam int QDEPTH  = 4;
    localparam int QPTR_W  = 2;
    localparam int QCNT_W  = 3;

    // Request kinds.
    localparam logic KIND_LOAD  = 1'b0;
    localparam logic KIND_QUERY = 1'b1;

    localparam logic [DIST_W-1:0] DIST_MAX = '1;

    // Head of the command queue as seen by the back end.
    typedef struct packed {
        logic valid;
        logic query;
    } t_cmd_ctl;

endpackage

### hw/rtl/nps_ram.sv
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module nps_ram #(
    parameter int WIDTH = 72,
    parameter int DEPTH = 1024,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

### hw/rtl/nps_front.sv
// ----------------------------------------------------------------------------
// Nearest point search front end
// Accepts requests, drops loads to slots outside the store and queues the
// rest in order for the back end.
// ----------------------------------------------------------------------------
module nps_front #(
    parameter int MAX_POINTS = 1024,
    parameter int COORD_BITS = 24
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  logic                          i_kind,
    input  logic [nps_pkg::SLOT_W-1:0]    i_slot,
    input  logic signed [COORD_BITS-1:0]  i_coord_x,
    input  logic signed [COORD_BITS-1:0]  i_coord_y,
    input  logic signed [COORD_BITS-1:0]  i_coord_z,
    output nps_pkg::t_cmd_ctl             o_head,
    output logic [nps_pkg::SLOT_W-1:0]    o_head_slot,
    output logic [3*COORD_BITS-1:0]       o_head_point,
    input  logic                          i_pop
);
    import nps_pkg::*;

    logic                    r_q_kind  [QDEPTH];
    logic [SLOT_W-1:0]       r_q_slot  [QDEPTH];
    logic [3*COORD_BITS-1:0] r_q_point [QDEPTH];
    logic [QPTR_W-1:0]       r_wr_ptr;
    logic [QPTR_W-1:0]       r_rd_ptr;
    logic [QCNT_W-1:0]       r_count;
    logic                    w_in_range;
    logic                    w_push;
    logic                    w_pop;

    assign o_in_ready = (r_count != QCNT_W'(QDEPTH));
    assign w_in_range = (17'(i_slot) < 17'(MAX_POINTS));
    // A load to a slot beyond the store is accepted and then forgotten.
    assign w_push     = i_in_valid && o_in_ready && (i_kind == KIND_QUERY || w_in_range);
    assign w_pop      = i_pop && (r_count != '0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (w_push) begin
                r_wr_ptr <= r_wr_ptr + QPTR_W'(1);
            end
            if (w_pop) begin
                r_rd_ptr <= r_rd_ptr + QPTR_W'(1);
            end
            if (w_push && !w_pop) begin
                r_count <= r_count + QCNT_W'(1);
            end else if (!w_push && w_pop) begin
                r_count <= r_count - QCNT_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_q_kind[r_wr_ptr]  <= i_kind;
            r_q_slot[r_wr_ptr]  <= i_slot;
            r_q_point[r_wr_ptr] <= {i_coord_z, i_coord_y, i_coord_x};
        end
    end

    assign o_head.valid = (r_count != '0);
    assign o_head.query = (r_q_kind[r_rd_ptr] == KIND_QUERY);
    assign o_head_slot  = r_q_slot[r_rd_ptr];
    assign o_head_point = r_q_point[r_rd_ptr];

endmodule

### hw/rtl/nps_back.sv
// ----------------------------------------------------------------------------
// Nearest point search back end
// Writes loads into the target store and scans it for queries through a
// distance pipeline: read, difference, square, sum, compare.
// ----------------------------------------------------------------------------
module nps_back #(
    parameter int MAX_POINTS = 1024,
    parameter int COORD_BITS = 24
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_wr_en,
    input  logic [nps_pkg::CNT_W-1:0]     i_cfg_wr_data,
    input  nps_pkg::t_cmd_ctl             i_head,
    input  logic [nps_pkg::SLOT_W-1:0]    i_head_slot,
    input  logic [3*COORD_BITS-1:0]       i_head_point,
    output logic                          o_pop,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output logic                          o_found,
    output logic [nps_pkg::IDX_W-1:0]     o_nearest_index,
    output logic [nps_pkg::DIST_W-1:0]    o_squared_distance
);
    import nps_pkg::*;

    localparam int CB = COORD_BITS;
    localparam int AW = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
    localparam int NW = $clog2(MAX_POINTS + 1);
    localparam int SQ_W = 2 * CB + 1;
    localparam int SUM_W = 2 * CB + 3;
    localparam int EXT_W = (SUM_W > DIST_W) ? SUM_W : DIST_W;

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_SCAN  = 2'd1;
    localparam logic [1:0] S_DRAIN = 2'd2;
    localparam logic [1:0] S_DONE  = 2'd3;

    logic [CNT_W-1:0]      r_cfg_count;
    logic [1:0]            r_state;
    logic [1:0]            n_state;

    logic signed [CB-1:0]  r_qx, r_qy, r_qz;
    logic [AW-1:0]         r_addr;
    logic [AW-1:0]         r_last_addr;

    logic                  r_v1, r_v2, r_v3, r_v4;
    logic                  r_l1, r_l2, r_l3, r_l4;
    logic [AW-1:0]         r_i1, r_i2, r_i3, r_i4;
    logic signed [CB:0]    r_dx, r_dy, r_dz;
    logic [SQ_W-1:0]       r_sx, r_sy, r_sz;
    logic [DIST_W-1:0]     r_d4;

    logic                  r_have;
    logic [AW-1:0]         r_best_i;
    logic [DIST_W-1:0]     r_best_d;

    logic                  r_out_valid;
    logic                  r_out_found;
    logic [IDX_W-1:0]      r_out_index;
    logic [DIST_W-1:0]     r_out_dist;

    logic                  w_take;
    logic                  w_scan;
    logic                  w_scan_last;
    logic [NW-1:0]         w_n;
    logic [3*CB-1:0]       w_rdata;
    logic signed [CB-1:0]  w_tx, w_ty, w_tz;
    logic signed [2*CB+1:0] w_px, w_py, w_pz;
    logic [SUM_W-1:0]      w_sum;
    logic [EXT_W-1:0]      w_sum_ext;
    logic                  w_out_free;

    // Scan length: the count register, capped at the store depth.
    assign w_n = (17'(r_cfg_count) > 17'(MAX_POINTS)) ? NW'(MAX_POINTS) : NW'(r_cfg_count);

    assign w_take      = (r_state == S_IDLE) && i_head.valid;
    assign o_pop       = w_take;
    assign w_scan      = (r_state == S_SCAN);
    assign w_scan_last = w_scan && (r_addr == r_last_addr);
    assign w_out_free  = !r_out_valid || i_out_ready;

    nps_ram #(
        .WIDTH (3 * CB),
        .DEPTH (MAX_POINTS)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (w_take && !i_head.query),
        .i_waddr (AW'(i_head_slot)),
        .i_wdata (i_head_point),
        .i_re    (w_scan),
        .i_raddr (r_addr),
        .o_rdata (w_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_count <= '0;
        end else if (i_cfg_wr_en) begin
            r_cfg_count <= i_cfg_wr_data;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (w_take && i_head.query) begin
                    n_state = (w_n == '0) ? S_DONE : S_SCAN;
                end
            end
            S_SCAN: begin
                if (w_scan_last) begin
                    n_state = S_DRAIN;
                end
            end
            S_DRAIN: begin
                if (r_v4 && r_l4) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (w_out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_v1    <= 1'b0;
            r_v2    <= 1'b0;
            r_v3    <= 1'b0;
            r_v4    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_v1    <= w_scan;
            r_v2    <= r_v1;
            r_v3    <= r_v2;
            r_v4    <= r_v3;
        end
    end

    // Query setup and scan address.
    always_ff @(posedge i_clk) begin
        if (w_take && i_head.query) begin
            r_qx        <= i_head_point[CB-1:0];
            r_qy        <= i_head_point[2*CB-1:CB];
            r_qz        <= i_head_point[3*CB-1:2*CB];
            r_addr      <= '0;
            r_last_addr <= AW'(w_n - NW'(1));
        end else if (w_scan) begin
            r_addr <= r_addr + AW'(1);
        end
    end

    assign w_tx = w_rdata[CB-1:0];
    assign w_ty = w_rdata[2*CB-1:CB];
    assign w_tz = w_rdata[3*CB-1:2*CB];

    assign w_px = r_dx * r_dx;
    assign w_py = r_dy * r_dy;
    assign w_pz = r_dz * r_dz;

    assign w_sum     = SUM_W'(r_sx) + SUM_W'(r_sy) + SUM_W'(r_sz);
    assign w_sum_ext = EXT_W'(w_sum);

    // Distance pipeline payload.
    always_ff @(posedge i_clk) begin
        r_i1 <= r_addr;
        r_l1 <= w_scan_last;
        r_i2 <= r_i1;
        r_l2 <= r_l1;
        r_i3 <= r_i2;
        r_l3 <= r_l2;
        r_i4 <= r_i3;
        r_l4 <= r_l3;
        r_dx <= {r_qx[CB-1], r_qx} - {w_tx[CB-1], w_tx};
        r_dy <= {r_qy[CB-1], r_qy} - {w_ty[CB-1], w_ty};
        r_dz <= {r_qz[CB-1], r_qz} - {w_tz[CB-1], w_tz};
        r_sx <= w_px[SQ_W-1:0];
        r_sy <= w_py[SQ_W-1:0];
        r_sz <= w_pz[SQ_W-1:0];
        r_d4 <= (w_sum_ext > EXT_W'(DIST_MAX)) ? DIST_MAX : w_sum_ext[DIST_W-1:0];
    end

    // Running best; only a strictly smaller distance replaces it.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_have <= 1'b0;
        end else if (w_take && i_head.query) begin
            r_have <= 1'b0;
        end else if (r_v4 && (!r_have || r_d4 < r_best_d)) begin
            r_have <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_take && i_head.query) begin
            r_best_i <= '0;
            r_best_d <= '0;
        end else if (r_v4 && (!r_have || r_d4 < r_best_d)) begin
            r_best_i <= r_i4;
            r_best_d <= r_d4;
        end
    end

    // Output register; a waiting result does not hold up loads behind it.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (r_state == S_DONE && w_out_free) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_DONE && w_out_free) begin
            r_out_found <= r_have;
            r_out_index <= IDX_W'(r_best_i);
            r_out_dist  <= r_best_d;
        end
    end

    assign o_out_valid        = r_out_valid;
    assign o_found            = r_out_found;
    assign o_nearest_index    = r_out_index;
    assign o_squared_distance = r_out_dist;

endmodule

### hw/rtl/nearest_point_search_top.sv
// ----------------------------------------------------------------------------
// Nearest point search
// Brute-force 3-D nearest neighbor over a store of loaded target points.
// ----------------------------------------------------------------------------
// A load request writes one point into the target store and occupies the
// scan engine only in the cycle it is taken. A query request scans slots 0 to
// min(target_count, MAX_POINTS) - 1, one stored point per cycle through the
// single read port of the store, and returns the lowest slot at the smallest
// exact squared distance; the result passes the store read port and the
// five-stage distance pipeline. A four entry request queue sits in front of
// the scan engine, so requests keep being accepted while a scan runs or a
// result waits to be taken. Slots must be loaded before a query scans them.
module nearest_point_search_top #(
    parameter int MAX_POINTS = 1024,
    parameter int COORD_BITS = 24
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_wr_en,
    input  logic [nps_pkg::CNT_W-1:0]     i_cfg_wr_data,
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  logic                          i_kind,
    input  logic [nps_pkg::SLOT_W-1:0]    i_slot,
    input  logic signed [COORD_BITS-1:0]  i_coord_x,
    input  logic signed [COORD_BITS-1:0]  i_coord_y,
    input  logic signed [COORD_BITS-1:0]  i_coord_z,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output logic                          o_found,
    output logic [nps_pkg::IDX_W-1:0]     o_nearest_index,
    output logic [nps_pkg::DIST_W-1:0]    o_squared_distance
);
    import nps_pkg::*;

    t_cmd_ctl                w_head;
    logic [SLOT_W-1:0]       w_head_slot;
    logic [3*COORD_BITS-1:0] w_head_point;
    logic                    w_pop;

    nps_front #(
        .MAX_POINTS (MAX_POINTS),
        .COORD_BITS (COORD_BITS)
    ) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_ready   (o_in_ready),
        .i_kind       (i_kind),
        .i_slot       (i_slot),
        .i_coord_x    (i_coord_x),
        .i_coord_y    (i_coord_y),
        .i_coord_z    (i_coord_z),
        .o_head       (w_head),
        .o_head_slot  (w_head_slot),
        .o_head_point (w_head_point),
        .i_pop        (w_pop)
    );

    nps_back #(
        .MAX_POINTS (MAX_POINTS),
        .COORD_BITS (COORD_BITS)
    ) u_back (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cfg_wr_en        (i_cfg_wr_en),
        .i_cfg_wr_data      (i_cfg_wr_data),
        .i_head             (w_head),
        .i_head_slot        (w_head_slot),
        .i_head_point       (w_head_point),
        .o_pop              (w_pop),
        .o_out_valid        (o_out_valid),
        .i_out_ready        (i_out_ready),
        .o_found            (o_found),
        .o_nearest_index    (o_nearest_index),
        .o_squared_distance (o_squared_distance)
    );

endmodule

### test/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Nearest point search testbench
// Loads target points and issues queries through the request channel. The
// expected slot and squared distance of every query are computed here from a
// private copy of the target store and checked against each result in order.
// ----------------------------------------------------------------------------
module tb;
    import nps_pkg::*;

    localparam int MAX_PTS       = 1024;
    localparam int FILL_PTS      = 128;
    localparam int COORD_W       = 24;
    localparam int SETTLE_CYCLES = 16;
    localparam int END_CYCLES    = 40;
    localparam int HOLD_CYCLES   = 400;
    localparam int RANDOM_ITEMS  = 400;
    localparam int CYCLE_LIMIT   = 3000000;

    typedef logic signed [COORD_W-1:0] t_coord;

    typedef struct packed {
        t_coord x;
        t_coord y;
        t_coord z;
    } t_point;

    typedef struct packed {
        logic              found;
        logic [IDX_W-1:0]  nearest;
        logic [DIST_W-1:0] distance;
    } t_nearest_result;

    localparam t_coord COORD_MAX = {1'b0, {(COORD_W-1){1'b1}}};
    localparam t_coord COORD_MIN = {1'b1, {(COORD_W-1){1'b0}}};

    class nearest_point_checker;
        t_point            targets [MAX_PTS];
        logic [CNT_W-1:0]  target_count;
        t_nearest_result   expected_nearest_q [$];
        int                errors;
        int                results_seen;

        function new();
            target_count = '0;
            errors = 0;
            results_seen = 0;
        endfunction

        function void set_count(logic [CNT_W-1:0] n);
            target_count = n;
        endfunction

        function int scan_length();
            return (target_count > MAX_PTS) ? MAX_PTS : int'(target_count);
        endfunction

        function t_point target_at(int slot);
            return targets[slot];
        endfunction

        function int pending();
            return expected_nearest_q.size();
        endfunction

        function longint unsigned axis_sq(t_coord a, t_coord b);
            longint d;
            d = longint'(a) - longint'(b);
            if (d < 0) begin
                d = -d;
            end
            return d * d;
        endfunction

        function void note_request(logic kind, logic [SLOT_W-1:0] slot, t_point p);
            t_nearest_result best;
            longint unsigned d;
            if (kind == KIND_LOAD) begin
                targets[slot] = p;
                return;
            end
            best = '0;
            for (int j = 0; j < scan_length(); j++) begin
                d = axis_sq(p.x, targets[j].x) + axis_sq(p.y, targets[j].y)
                    + axis_sq(p.z, targets[j].z);
                // Only a strictly closer point displaces the current best.
                if (!best.found || d < best.distance) begin
                    best.found = 1'b1;
                    best.nearest = IDX_W'(j);
                    best.distance = DIST_W'(d);
                end
            end
            expected_nearest_q.push_back(best);
        endfunction

        function void note_failure(string msg);
            errors++;
            if (errors <= 10) begin
                $display("%0t: result %0d: %s", $time, results_seen, msg);
            end
        endfunction

        function void check_result(logic found, logic [IDX_W-1:0] nearest,
                                   logic [DIST_W-1:0] distance);
            t_nearest_result want;
            results_seen++;
            if (expected_nearest_q.size() == 0) begin
                note_failure($sformatf("unexpected result found=%0d index=%0d distance=%0d",
                                       found, nearest, distance));
                return;
            end
            want = expected_nearest_q.pop_front();
            if (want.found !== found || want.nearest !== nearest
                || want.distance !== distance) begin
                note_failure($sformatf({"expected found=%0d index=%0d distance=%0d, ",
                                        "got found=%0d index=%0d distance=%0d"},
                                       want.found, want.nearest, want.distance,
                                       found, nearest, distance));
            end
        endfunction
    endclass

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_cfg_wr_en = 1'b0;
    logic [CNT_W-1:0]   i_cfg_wr_data = '0;
    logic               i_in_valid = 1'b0;
    logic               o_in_ready;
    logic               i_kind = KIND_LOAD;
    logic [SLOT_W-1:0]  i_slot = '0;
    t_coord             i_coord_x = '0;
    t_coord             i_coord_y = '0;
    t_coord             i_coord_z = '0;
    logic               o_out_valid;
    logic               i_out_ready = 1'b0;
    logic               o_found;
    logic [IDX_W-1:0]   o_nearest_index;
    logic [DIST_W-1:0]  o_squared_distance;

    nearest_point_checker sb;
    bit tx_idle = 1'b1;
    bit rx_idle = 1'b1;
    int rx_hold_len = 0;

    nearest_point_search_top #(
        .MAX_POINTS (MAX_PTS),
        .COORD_BITS (COORD_W)
    ) dut (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cfg_wr_en        (i_cfg_wr_en),
        .i_cfg_wr_data      (i_cfg_wr_data),
        .i_in_valid         (i_in_valid),
        .o_in_ready         (o_in_ready),
        .i_kind             (i_kind),
        .i_slot             (i_slot),
        .i_coord_x          (i_coord_x),
        .i_coord_y          (i_coord_y),
        .i_coord_z          (i_coord_z),
        .o_out_valid        (o_out_valid),
        .i_out_ready        (i_out_ready),
        .o_found            (o_found),
        .o_nearest_index    (o_nearest_index),
        .o_squared_distance (o_squared_distance)
    );

    always #2 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) begin
            sb.check_result(o_found, o_nearest_index, o_squared_distance);
        end
    end

    // Result side: a random stall per result, plus an occasional long hold-off
    // that lets the request queue fill up behind it.
    initial begin : result_sink
        int gap;
        int hold;
        wait (i_rst_n === 1'b1);
        @(posedge i_clk);
        forever begin
            hold = rx_hold_len;
            rx_hold_len = 0;
            gap = rx_idle ? $urandom_range(0, 19) : 0;
            if (hold + gap != 0) begin
                i_out_ready <= 1'b0;
                repeat (hold + gap) @(posedge i_clk);
            end
            i_out_ready <= 1'b1;
            do @(posedge i_clk); while (!(o_out_valid && i_out_ready));
        end
    end

    initial begin : watchdog
        int cycles;
        cycles = 0;
        while (cycles < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycles++;
        end
        $display("tb failed");
        $finish;
    end

    function automatic t_coord vary_coord(t_coord base, int mode);
        case (mode)
            0: return t_coord'($urandom);
            1: return t_coord'(base + $urandom_range(0, 511) - 256);
            2: return base;
            3: begin
                case ($urandom_range(0, 4))
                    0: return COORD_MIN;
                    1: return COORD_MAX;
                    2: return t_coord'(0);
                    3: return t_coord'(-1);
                    default: return t_coord'(1);
                endcase
            end
            default: return t_coord'($urandom_range(0, 1023) - 512);
        endcase
    endfunction

    // A point that is random, near a stored target, equal to it, on the
    // extremes of the range, or close to the origin.
    function automatic t_point make_point(t_point base);
        int mode;
        t_point p;
        mode = $urandom_range(0, 4);
        p.x = vary_coord(base.x, mode);
        p.y = vary_coord(base.y, mode);
        p.z = vary_coord(base.z, mode);
        return p;
    endfunction

    function automatic logic [CNT_W-1:0] pick_count();
        int r;
        r = $urandom_range(0, 99);
        if (r < 5) begin
            return '0;
        end else if (r < 10) begin
            return CNT_W'(FILL_PTS);
        end else if (r < 30) begin
            return CNT_W'($urandom_range(65, FILL_PTS));
        end
        return CNT_W'($urandom_range(1, 64));
    endfunction

    task automatic send_request(input logic kind, input logic [SLOT_W-1:0] slot,
                                input t_point p);
        int gap;
        gap = tx_idle ? $urandom_range(0, 19) : 0;
        if (gap != 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_kind <= kind;
        i_slot <= slot;
        i_coord_x <= p.x;
        i_coord_y <= p.y;
        i_coord_z <= p.z;
        do @(posedge i_clk); while (!o_in_ready);
        sb.note_request(kind, slot, p);
    endtask

    task automatic wait_drained();
        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (sb.pending() != 0);
    endtask

    // Loads produce no result, so the block may still be busy after the last
    // result; give it time before the count changes.
    task automatic write_target_count(input logic [CNT_W-1:0] n);
        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        i_cfg_wr_en <= 1'b1;
        i_cfg_wr_data <= n;
        @(posedge i_clk);
        i_cfg_wr_en <= 1'b0;
        sb.set_count(n);
    endtask

    initial begin : stimulus
        t_point base;
        int sent;
        int scan;
        logic [SLOT_W-1:0] slot;
        sb = new();
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Empty scan returns nothing found.
        write_target_count('0);
        send_request(KIND_QUERY, SLOT_W'($urandom), {COORD_MAX, COORD_MAX, COORD_MAX});

        send_request(KIND_LOAD, SLOT_W'(0), {COORD_MAX, COORD_MAX, COORD_MAX});
        send_request(KIND_LOAD, SLOT_W'(1), {COORD_MIN, COORD_MIN, COORD_MIN});
        send_request(KIND_LOAD, SLOT_W'(2), '0);
        send_request(KIND_LOAD, SLOT_W'(3), {COORD_MIN, COORD_MIN, COORD_MIN});
        send_request(KIND_LOAD, SLOT_W'(4), {t_coord'(2), t_coord'(0), t_coord'(0)});
        send_request(KIND_LOAD, SLOT_W'(MAX_PTS - 1),
                     {t_coord'(-1), t_coord'(1), t_coord'(-256)});

        // One target at the far corner gives the largest possible distance.
        write_target_count(CNT_W'(1));
        send_request(KIND_QUERY, SLOT_W'($urandom), {COORD_MIN, COORD_MIN, COORD_MIN});

        // Duplicate and equidistant targets must resolve to the lowest slot.
        write_target_count(CNT_W'(5));
        send_request(KIND_QUERY, SLOT_W'($urandom), {COORD_MIN, COORD_MIN, COORD_MIN});
        send_request(KIND_QUERY, SLOT_W'($urandom), {COORD_MAX, COORD_MAX, COORD_MAX});
        send_request(KIND_QUERY, SLOT_W'($urandom), '0);
        send_request(KIND_QUERY, SLOT_W'($urandom), {t_coord'(1), t_coord'(0), t_coord'(0)});
        send_request(KIND_QUERY, SLOT_W'($urandom),
                     {t_coord'(-1), t_coord'(-1), t_coord'(-1)});

        // Fill the low end of the store; every count from here on stays inside it.
        tx_idle = 1'b0;
        for (int s = 0; s < FILL_PTS; s++) begin
            send_request(KIND_LOAD, SLOT_W'(s), make_point('0));
        end
        tx_idle = 1'b1;

        write_target_count(CNT_W'(FILL_PTS));
        send_request(KIND_QUERY, SLOT_W'($urandom), sb.target_at(FILL_PTS - 1));
        send_request(KIND_QUERY, SLOT_W'($urandom), sb.target_at(0));
        send_request(KIND_QUERY, SLOT_W'($urandom), make_point(sb.target_at(97)));

        // Long result stall while requests keep coming.
        write_target_count(CNT_W'(8));
        tx_idle = 1'b0;
        rx_hold_len = HOLD_CYCLES;
        repeat (24) begin
            send_request(KIND_QUERY, SLOT_W'($urandom),
                         make_point(sb.target_at($urandom_range(0, 7))));
        end
        wait_drained();

        sent = 0;
        while (sent < RANDOM_ITEMS) begin
            write_target_count(pick_count());
            tx_idle = ($urandom_range(0, 3) != 0);
            rx_idle = ($urandom_range(0, 3) != 0);
            if ($urandom_range(0, 9) == 0) begin
                rx_hold_len = HOLD_CYCLES;
            end
            scan = sb.scan_length();
            repeat ($urandom_range(20, 60)) begin
                if ($urandom_range(0, 19) == 0) begin
                    wait_drained();
                end
                if ($urandom_range(0, 99) < 45) begin
                    if (scan != 0 && $urandom_range(0, 1) == 0) begin
                        slot = SLOT_W'($urandom_range(0, scan - 1));
                    end else begin
                        slot = SLOT_W'($urandom_range(0, MAX_PTS - 1));
                    end
                    base = sb.target_at($urandom_range(0, FILL_PTS - 1));
                    send_request(KIND_LOAD, slot, make_point(base));
                end else begin
                    base = sb.target_at(scan == 0 ? $urandom_range(0, FILL_PTS - 1)
                                                  : $urandom_range(0, scan - 1));
                    send_request(KIND_QUERY, SLOT_W'($urandom), make_point(base));
                end
                sent++;
            end
        end

        wait_drained();
        repeat (END_CYCLES) @(posedge i_clk);
        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("tb passed");
        end else begin
            $display("tb failed");
        end
        $finish;
    end

endmodule
